>>> rtl/rti_pkg.sv
// Package with the shared types, constants and register indexes of the inlier test.
`default_nettype none

package rti_pkg;

   // Width of one rotation entry slot in a packed rotation row.
   localparam int ROT_SLOT = 16;
   // Width of the configuration data, the error sum and the threshold.
   localparam int ERR_W = 48;
   localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
   // Residual magnitudes are clamped to 2^24 before squaring.
   localparam int CLAMP_W = 25;
   localparam logic [CLAMP_W-1:0] RES_CLAMP = 25'h1000000;
   localparam int SQ_W = 2 * CLAMP_W;
   // Six squares are summed before saturation.
   localparam int SUM6_W = SQ_W + 3;

   // A 3x3 rotation matrix, indexed [row][column].
   typedef logic [2:0][2:0][ROT_SLOT-1:0] rot_mat_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_ROT_ROW0  = 3'd0,
      CSR_ROT_ROW1  = 3'd1,
      CSR_ROT_ROW2  = 3'd2,
      CSR_SHIFT_X   = 3'd3,
      CSR_SHIFT_Y   = 3'd4,
      CSR_SHIFT_Z   = 3'd5,
      CSR_THRESHOLD = 3'd6
   } csr_index_type;

endpackage : rti_pkg

`default_nettype wire

>>> rtl/rti_mat_vec.sv
// Two-stage pipelined 3x3 matrix times vector product with rounding to 16 fraction bits.
`default_nettype none

module rti_mat_vec
   import rti_pkg::*;
#(
   parameter int VEC_W         = 25,
   parameter int ROT_FRAC_BITS = 14,
   parameter int OUT_W         = VEC_W + ROT_SLOT + 2
) (
   input  wire logic                    clock,
   input  wire rot_mat_type             rot,
   input  wire logic signed [VEC_W-1:0] vec [3],
   output logic signed [OUT_W-1:0]      rounded [3]
);

   localparam int PROD_W = VEC_W + ROT_SLOT;
   localparam logic signed [OUT_W-1:0] RND_BIAS = OUT_W'(1) <<< (ROT_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [OUT_W-1:0]  rnd_in [3];
   logic signed [OUT_W-1:0]  rnd_ff [3];

   // First stage: nine independent products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(rot[i][j]) * vec[j];
         end
      end
   end

   // Second stage: exact row sums, then round half up to 16 fraction bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_in[i] = (OUT_W'(prod_ff[i][0]) + OUT_W'(prod_ff[i][1]) + OUT_W'(prod_ff[i][2])
                      + RND_BIAS) >>> ROT_FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rnd_ff  <= rnd_in;
   end

   assign rounded = rnd_ff;

endmodule : rti_mat_vec

`default_nettype wire

>>> rtl/rigid_transform_inlier_test.sv
// Top level of the rigid-transform inlier test: registers, residual pipeline and result.
`default_nettype none

// Usage.
// A correspondence (model point and data point, Q8.16 coordinates) is one word on the
// request ports; it is taken at a rising edge with start high and busy low. Busy never
// rises, so one word may be taken in every cycle.
// Each word gives exactly one result word on the rsp_ ports, shown for one cycle and
// marked by rsp_valid. The receiver cannot hold results off, and none are needed: the
// pipeline never stalls, so a sustained rate of one word per cycle holds at any input
// pattern. The seven stages are input capture, the rotation products, the rounded row
// sums, the residuals with their clamp, the squares, the sum of six squares, and the
// saturation with the threshold compare.
// The configuration port takes one register word per cycle (csr_ready is always high);
// write only while no word is in flight, since later stages read the registers live.
// Reset is synchronous: it empties the valid pipeline, loads the identity rotation and
// clears the translation and the threshold. Nothing needs clearing beyond that.
// A zero threshold makes every point an outlier, and a saturated sum is never an inlier.

module rigid_transform_inlier_test
   import rti_pkg::*;
#(
   parameter int COORD_WIDTH   = 24,
   parameter int ROT_FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_model_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_model_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_model_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_data_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_data_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_data_z,
   // Result channel.
   output logic                               rsp_valid,
   output logic                               rsp_is_inlier,
   output logic [ERR_W-1:0]                   rsp_error_sum,
   // Configuration port.
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [ERR_W-1:0]              csr_wdata
);

   // Vectors into the matrix units carry one extra bit so that m - T is exact.
   localparam int VEC_W = COORD_WIDTH + 1;
   localparam int RND_W = VEC_W + ROT_SLOT + 2;
   localparam int RES_W = RND_W + 2;
   localparam int LATENCY = 7;

   // Configuration registers; the reset rotation is the identity.
   logic [ERR_W-1:0]             rot_row_ff [3];
   logic signed [COORD_WIDTH-1:0] shift_ff [3];
   logic [ERR_W-1:0]             threshold_ff;

   // Valid bits that travel with the words.
   logic [LATENCY-2:0] valid_ff;

   // Stage one: captured points and the model point less the translation.
   logic signed [COORD_WIDTH-1:0] model1_ff [3];
   logic signed [VEC_W-1:0]       data1_ff [3];
   logic signed [VEC_W-1:0]       mt1_ff [3];
   // Points delayed to meet the matrix unit outputs.
   logic signed [COORD_WIDTH-1:0] model2_ff [3];
   logic signed [COORD_WIDTH-1:0] model3_ff [3];
   logic signed [COORD_WIDTH-1:0] data2_ff [3];
   logic signed [COORD_WIDTH-1:0] data3_ff [3];

   rot_mat_type             rot_fwd;
   rot_mat_type             rot_bwd;
   logic signed [RND_W-1:0] fwd3 [3];
   logic signed [RND_W-1:0] bwd3 [3];

   // Stage four: clamped residual magnitudes, forward in 0..2 and backward in 3..5.
   logic [CLAMP_W-1:0] mag4_in [6];
   logic [CLAMP_W-1:0] mag4_ff [6];
   // Stage five: squares. Stage six: their sum.
   logic [SQ_W-1:0]    sq5_ff [6];
   logic [SUM6_W-1:0]  sum6_in;
   logic [SUM6_W-1:0]  sum6_ff;
   // Stage seven: the result word.
   logic [ERR_W-1:0]   sat7_in;
   logic               rsp_valid_ff;
   logic               rsp_is_inlier_ff;
   logic [ERR_W-1:0]   rsp_error_sum_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= ERR_W'(48'h0000_0000_4000);
         rot_row_ff[1] <= ERR_W'(48'h0000_4000_0000);
         rot_row_ff[2] <= ERR_W'(48'h4000_0000_0000);
         shift_ff[0]   <= '0;
         shift_ff[1]   <= '0;
         shift_ff[2]   <= '0;
         threshold_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROT_ROW0:  rot_row_ff[0] <= csr_wdata;
            CSR_ROT_ROW1:  rot_row_ff[1] <= csr_wdata;
            CSR_ROT_ROW2:  rot_row_ff[2] <= csr_wdata;
            CSR_SHIFT_X:   shift_ff[0]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Y:   shift_ff[1]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Z:   shift_ff[2]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_THRESHOLD: threshold_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The forward mapping uses R and the backward mapping its transpose.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rot_fwd[i][j] = rot_row_ff[i][ROT_SLOT*j +: ROT_SLOT];
            rot_bwd[i][j] = rot_row_ff[j][ROT_SLOT*i +: ROT_SLOT];
         end
      end
   end

   // Of the pipeline state, only the valid bits and the result strobe are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[LATENCY-3:0], start && !busy};
         rsp_valid_ff <= valid_ff[LATENCY-2];
      end
   end

   // Stage one capture.
   always_ff @(posedge clock) begin
      model1_ff[0] <= req_model_x;
      model1_ff[1] <= req_model_y;
      model1_ff[2] <= req_model_z;
      data1_ff[0]  <= VEC_W'(req_data_x);
      data1_ff[1]  <= VEC_W'(req_data_y);
      data1_ff[2]  <= VEC_W'(req_data_z);
      mt1_ff[0]    <= VEC_W'(req_model_x) - VEC_W'(shift_ff[0]);
      mt1_ff[1]    <= VEC_W'(req_model_y) - VEC_W'(shift_ff[1]);
      mt1_ff[2]    <= VEC_W'(req_model_z) - VEC_W'(shift_ff[2]);
      for (int i = 0; i < 3; i++) begin
         model2_ff[i] <= model1_ff[i];
         model3_ff[i] <= model2_ff[i];
         data2_ff[i]  <= data1_ff[i][COORD_WIDTH-1:0];
         data3_ff[i]  <= data2_ff[i];
      end
   end

   // Stages two and three: R d and R^T (m - T), rounded.
   rti_mat_vec #(
      .VEC_W         (VEC_W),
      .ROT_FRAC_BITS (ROT_FRAC_BITS),
      .OUT_W         (RND_W)
   ) u_fwd (
      .clock   (clock),
      .rot     (rot_fwd),
      .vec     (data1_ff),
      .rounded (fwd3)
   );

   rti_mat_vec #(
      .VEC_W         (VEC_W),
      .ROT_FRAC_BITS (ROT_FRAC_BITS),
      .OUT_W         (RND_W)
   ) u_bwd (
      .clock   (clock),
      .rot     (rot_bwd),
      .vec     (mt1_ff),
      .rounded (bwd3)
   );

   // Stage four: exact residuals, then magnitudes clamped to 2^24. A clamped square
   // already reaches the saturation level, so the clamp leaves the result unchanged.
   always_comb begin
      logic signed [RES_W-1:0] res [6];
      logic [RES_W-1:0]        mag;
      for (int i = 0; i < 3; i++) begin
         res[i]     = RES_W'(model3_ff[i]) - (RES_W'(fwd3[i]) + RES_W'(shift_ff[i]));
         res[i + 3] = RES_W'(data3_ff[i]) - RES_W'(bwd3[i]);
      end
      for (int k = 0; k < 6; k++) begin
         mag = res[k][RES_W-1] ? RES_W'(-res[k]) : RES_W'(res[k]);
         if (mag > RES_W'(RES_CLAMP)) begin
            mag4_in[k] = RES_CLAMP;
         end else begin
            mag4_in[k] = mag[CLAMP_W-1:0];
         end
      end
   end

   // Stage six: the six squares summed without loss.
   always_comb begin
      sum6_in = '0;
      for (int k = 0; k < 6; k++) begin
         sum6_in = sum6_in + SUM6_W'(sq5_ff[k]);
      end
   end

   // Stage seven: saturate to 48 bits.
   assign sat7_in = (sum6_ff > SUM6_W'(ERR_MAX)) ? ERR_MAX : sum6_ff[ERR_W-1:0];

   always_ff @(posedge clock) begin
      mag4_ff <= mag4_in;
      for (int k = 0; k < 6; k++) begin
         sq5_ff[k] <= mag4_ff[k] * mag4_ff[k];
      end
      sum6_ff          <= sum6_in;
      rsp_error_sum_ff <= sat7_in;
      rsp_is_inlier_ff <= sat7_in < threshold_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_inlier = rsp_is_inlier_ff;
   assign rsp_error_sum = rsp_error_sum_ff;

   // Every accepted word must be followed by a result strobe.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("accepted word did not produce a result after the pipeline latency");

   // An inlier flag agrees with the threshold that was live when it was computed.
   a_inlier_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_inlier) |-> (rsp_error_sum < $past(threshold_ff)))
      else $error("inlier flagged with an error sum not below the threshold");

   // Reset empties the pipeline, so no result follows it directly.
   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe raised directly after reset");

endmodule : rigid_transform_inlier_test

`default_nettype wire
